// ===== design/dpba_pkg.sv =====
// shared types, codes and helpers for the dual pool bitmap allocator
package dpba_pkg;

  // default pool sizes in entries
  localparam int BLOCK_BITS_DEF = 128;
  localparam int INODE_BITS_DEF = 32;

  // width of a pool size when compared against an entry number
  localparam int SIZE_W = 11;

  // request kinds
  localparam logic [1:0] K_ALLOC = 2'd0;
  localparam logic [1:0] K_FREE  = 2'd1;
  localparam logic [1:0] K_MARK  = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_SAME  = 2'd3;

  // classified operation passed from front to back
  typedef enum logic [2:0] {
    OP_ALLOC,
    OP_FREE,
    OP_MARK,
    OP_RANGE,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t        op;
    logic       pool;
    logic [7:0] num;
  } cmd_t;

  typedef struct packed {
    logic [7:0] entry;
    logic [1:0] status;
    logic [7:0] free_left;
  } res_t;

  typedef struct packed {
    logic       none;
    logic [2:0] pos;
  } ffz_t;

  // lowest clear bit of a byte, lsb first
  function automatic ffz_t ffz8(input logic [7:0] w);
    ffz_t r;
    r.none = 1'b1;
    r.pos  = 3'd0;
    for (int b = 7; b >= 0; b--) begin
      if (!w[b]) begin
        r.none = 1'b0;
        r.pos  = 3'(b);
      end
    end
    return r;
  endfunction

endpackage

// ===== design/dpba_fifo.sv =====
// two-entry register queue used between stages
module dpba_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  logic [WIDTH-1:0] slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) wr_ptr <= !wr_ptr;
      if (do_rd) rd_ptr <= !rd_ptr;
      if (do_wr && !do_rd) begin
        count <= count + 2'd1;
      end else if (do_rd && !do_wr) begin
        count <= count - 2'd1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) slots[wr_ptr] <= wr_data;
  end

endmodule

// ===== design/dpba_front.sv =====
// front end: takes requests, classifies them and queues them for the back end
module dpba_front #(
  parameter int BLOCK_BITS = dpba_pkg::BLOCK_BITS_DEF,
  parameter int INODE_BITS = dpba_pkg::INODE_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  logic [1:0]      kind,
  input  logic            pool,
  input  logic [7:0]      number,
  output logic            full,
  output logic            cmd_valid,
  output dpba_pkg::cmd_t  cmd,
  input  logic            cmd_take
);

  localparam logic [dpba_pkg::SIZE_W-1:0] BSIZE = dpba_pkg::SIZE_W'(BLOCK_BITS);
  localparam logic [dpba_pkg::SIZE_W-1:0] ISIZE = dpba_pkg::SIZE_W'(INODE_BITS);
  localparam int CMD_W = $bits(dpba_pkg::cmd_t);

  dpba_pkg::cmd_t             cls;
  logic                       num_out;
  logic [dpba_pkg::SIZE_W-1:0] num_wide;
  logic [CMD_W-1:0]           rd_data;
  logic                       empty;

  // range check against the addressed pool
  assign num_wide = dpba_pkg::SIZE_W'(number);
  assign num_out  = (number == 8'd0) || (pool ? (num_wide > ISIZE) : (num_wide > BSIZE));

  // classify the request
  always_comb begin
    cls.pool = pool;
    cls.num  = number;
    case (kind)
      dpba_pkg::K_ALLOC: cls.op = dpba_pkg::OP_ALLOC;
      dpba_pkg::K_FREE:  cls.op = num_out ? dpba_pkg::OP_RANGE : dpba_pkg::OP_FREE;
      dpba_pkg::K_MARK:  cls.op = num_out ? dpba_pkg::OP_RANGE : dpba_pkg::OP_MARK;
      default:           cls.op = dpba_pkg::OP_NOP;
    endcase
  end

  // command queue towards the back end
  dpba_fifo #(
    .WIDTH(CMD_W)
  ) u_cmd_q (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (push),
    .wr_data(cls),
    .full   (full),
    .rd_en  (cmd_take),
    .rd_data(rd_data),
    .empty  (empty)
  );

  assign cmd_valid = !empty;
  assign cmd       = dpba_pkg::cmd_t'(rd_data);

endmodule

// ===== design/dpba_back.sv =====
// back end: holds both bitmaps and free counts and carries out commands
module dpba_back #(
  parameter int BLOCK_BITS = dpba_pkg::BLOCK_BITS_DEF,
  parameter int INODE_BITS = dpba_pkg::INODE_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  input  dpba_pkg::cmd_t  cmd,
  output logic            cmd_take,
  input  logic            res_ready,
  output logic            res_valid,
  output dpba_pkg::res_t  res
);

  localparam int BWORDS = (BLOCK_BITS + 7) / 8;
  localparam int IWORDS = (INODE_BITS + 7) / 8;
  localparam int BIW    = (BWORDS > 1) ? $clog2(BWORDS) : 1;
  localparam int IIW    = (IWORDS > 1) ? $clog2(IWORDS) : 1;
  localparam int SW     = (BIW > IIW) ? BIW : IIW;
  localparam int BIX    = $clog2(BLOCK_BITS);
  localparam int IIX    = $clog2(INODE_BITS);
  localparam int BCW    = $clog2(BLOCK_BITS + 1);
  localparam int ICW    = $clog2(INODE_BITS + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t                state;
  state_t                state_next;
  logic [SW-1:0]         scan_w;
  logic [SW-1:0]         scan_w_next;
  logic                  scan_pool;
  logic                  scan_pool_next;
  logic [BLOCK_BITS-1:0] block_map;
  logic [INODE_BITS-1:0] inode_map;
  logic [BCW-1:0]        block_free;
  logic [BCW-1:0]        block_free_next;
  logic [ICW-1:0]        inode_free;
  logic [ICW-1:0]        inode_free_next;

  logic [BWORDS*8-1:0]   bpad;
  logic [IWORDS*8-1:0]   ipad;
  logic [7:0]            bword;
  logic [7:0]            iword;
  dpba_pkg::ffz_t        zf;
  logic                  last_word;
  logic [7:0]            num_m1;
  logic [BIX-1:0]        b_num_bit;
  logic [IIX-1:0]        i_num_bit;
  logic [BIX-1:0]        b_alloc_bit;
  logic [IIX-1:0]        i_alloc_bit;
  logic [BIX-1:0]        b_wr_bit;
  logic [IIX-1:0]        i_wr_bit;
  logic [SW+3:0]         alloc_num;
  logic                  cur_bit;
  logic                  want;
  logic                  wr_en;
  logic                  wr_val;
  logic                  pool_sel;
  logic [7:0]            res_entry;
  logic [1:0]            res_status;
  logic [7:0]            res_free;

  // padding past the pool end reads as used
  assign bpad = ~((BWORDS*8)'(~block_map));
  assign ipad = ~((IWORDS*8)'(~inode_map));

  // scan word of each pool and its lowest clear bit
  assign bword     = bpad[{BIW'(scan_w), 3'b000} +: 8];
  assign iword     = ipad[{IIW'(scan_w), 3'b000} +: 8];
  assign zf        = dpba_pkg::ffz8(scan_pool ? iword : bword);
  assign last_word = scan_pool ? (scan_w == SW'(IWORDS - 1)) : (scan_w == SW'(BWORDS - 1));

  assign b_alloc_bit = BIX'({BIW'(scan_w), zf.pos});
  assign i_alloc_bit = IIX'({IIW'(scan_w), zf.pos});
  assign alloc_num   = {1'b0, scan_w, zf.pos} + (SW+4)'(1);

  // direct access for free and mark
  assign num_m1    = cmd.num - 8'd1;
  assign b_num_bit = BIX'(num_m1);
  assign i_num_bit = IIX'(num_m1);
  assign cur_bit   = cmd.pool ? inode_map[i_num_bit] : block_map[b_num_bit];
  assign want      = (cmd.op == dpba_pkg::OP_MARK);

  assign pool_sel = (state == S_SCAN) ? scan_pool : cmd.pool;
  assign b_wr_bit = (state == S_SCAN) ? b_alloc_bit : b_num_bit;
  assign i_wr_bit = (state == S_SCAN) ? i_alloc_bit : i_num_bit;

  // command sequencing and result forming
  always_comb begin
    state_next     = state;
    scan_w_next    = scan_w;
    scan_pool_next = scan_pool;
    cmd_take       = 1'b0;
    res_valid      = 1'b0;
    wr_en          = 1'b0;
    wr_val         = 1'b0;
    res_entry      = 8'd0;
    res_status     = dpba_pkg::ST_OK;
    case (state)
      S_IDLE: begin
        if (cmd_valid && res_ready) begin
          cmd_take = 1'b1;
          case (cmd.op)
            dpba_pkg::OP_ALLOC: begin
              state_next     = S_SCAN;
              scan_w_next    = '0;
              scan_pool_next = cmd.pool;
            end
            dpba_pkg::OP_FREE, dpba_pkg::OP_MARK: begin
              res_valid = 1'b1;
              if (cur_bit == want) begin
                res_status = dpba_pkg::ST_SAME;
              end else begin
                wr_en     = 1'b1;
                wr_val    = want;
                res_entry = cmd.num;
              end
            end
            dpba_pkg::OP_RANGE: begin
              res_valid  = 1'b1;
              res_status = dpba_pkg::ST_RANGE;
            end
            default: begin
              res_valid = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (res_ready) begin
          if (!zf.none) begin
            res_valid  = 1'b1;
            wr_en      = 1'b1;
            wr_val     = 1'b1;
            res_entry  = 8'(alloc_num);
            state_next = S_IDLE;
          end else if (last_word) begin
            res_valid  = 1'b1;
            res_status = dpba_pkg::ST_FULL;
            state_next = S_IDLE;
          end else begin
            scan_w_next = scan_w + SW'(1);
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // free counts after this cycle's update
  always_comb begin
    block_free_next = block_free;
    inode_free_next = inode_free;
    if (wr_en && !pool_sel) begin
      block_free_next = wr_val ? block_free - BCW'(1) : block_free + BCW'(1);
    end
    if (wr_en && pool_sel) begin
      inode_free_next = wr_val ? inode_free - ICW'(1) : inode_free + ICW'(1);
    end
    res_free = pool_sel ? 8'(inode_free_next) : 8'(block_free_next);
  end

  assign res = {res_entry, res_status, res_free};

  // control state, bitmaps and counts
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      block_map  <= '0;
      inode_map  <= '0;
      block_free <= BCW'(BLOCK_BITS);
      inode_free <= ICW'(INODE_BITS);
    end else begin
      state      <= state_next;
      block_free <= block_free_next;
      inode_free <= inode_free_next;
      if (wr_en && !pool_sel) block_map[b_wr_bit] <= wr_val;
      if (wr_en && pool_sel) inode_map[i_wr_bit] <= wr_val;
    end
  end

  // scan position
  always_ff @(posedge clk) begin
    scan_w    <= scan_w_next;
    scan_pool <= scan_pool_next;
  end

endmodule

// ===== design/dual_pool_bitmap_allocator.sv =====
// top level of the dual pool bitmap allocator
//
//  channel   | handshake       | fields
//  ----------+-----------------+------------------------------
//  request   | push / full     | kind[1:0] pool number[7:0]
//  result    | pop / empty     | entry[7:0] status[1:0] free_left[7:0]
//
// free, mark, out-of-range and unused kinds are carried out from the idle state
// allocate scans the pool a byte at a time, 1 to ceil(pool size / 8) bytes,
// with the byte-wide find-first-zero scanner in the back end
// a request passes from the command queue through the back end into the result
// queue; an allocate also passes through the back end's scan state
// rst clears both bitmaps and reloads the free counts
// full rises when the two-entry command queue holds two requests; the back end
// waits while the two-entry result queue is full
module dual_pool_bitmap_allocator #(
  parameter int BLOCK_BITS = dpba_pkg::BLOCK_BITS_DEF,
  parameter int INODE_BITS = dpba_pkg::INODE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [1:0] kind,
  input  logic       pool,
  input  logic [7:0] number,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] entry,
  output logic [1:0] status,
  output logic [7:0] free_left
);

  localparam int RES_W = $bits(dpba_pkg::res_t);

  logic             cmd_valid;
  dpba_pkg::cmd_t   cmd;
  logic             cmd_take;
  logic             res_valid;
  dpba_pkg::res_t   res;
  logic             res_full;
  logic [RES_W-1:0] res_rd;
  dpba_pkg::res_t   res_out;

  // request classification and command queue
  dpba_front #(
    .BLOCK_BITS(BLOCK_BITS),
    .INODE_BITS(INODE_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .kind     (kind),
    .pool     (pool),
    .number   (number),
    .full     (full),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_take (cmd_take)
  );

  // bitmap execution
  dpba_back #(
    .BLOCK_BITS(BLOCK_BITS),
    .INODE_BITS(INODE_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_take (cmd_take),
    .res_ready(!res_full),
    .res_valid(res_valid),
    .res      (res)
  );

  // result queue
  dpba_fifo #(
    .WIDTH(RES_W)
  ) u_res_q (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (res_valid),
    .wr_data(res),
    .full   (res_full),
    .rd_en  (pop),
    .rd_data(res_rd),
    .empty  (empty)
  );

  assign res_out   = dpba_pkg::res_t'(res_rd);
  assign entry     = res_out.entry;
  assign status    = res_out.status;
  assign free_left = res_out.free_left;

  // back end only takes a command that is there
  a_take_valid: assert property (@(posedge clk) disable iff (rst)
    cmd_take |-> cmd_valid)
    else $error("command taken from empty queue");

  // no result transfer into a full result queue
  a_res_room: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !res_full)
    else $error("result pushed into full queue");

  // a failed operation reports entry zero
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.status != dpba_pkg::ST_OK) |-> (res.entry == 8'd0))
    else $error("failed operation with nonzero entry");

  // a full pool has no free entries left
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.status == dpba_pkg::ST_FULL) |-> (res.free_left == 8'd0))
    else $error("pool full with free entries counted");

endmodule
